### hw/rtl/tcsf_pkg.sv
package tcsf_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 64;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = PTR_W + 1;

  // Field widths
  localparam int WORD_W      = 64;
  localparam int COST_W      = 32;
  localparam int MAXD_W      = 7;
  localparam int REC_DEPTH_W = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  typedef logic [1:0] status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Result status codes
  localparam status_t ST_PUSHED    = 2'd0;
  localparam status_t ST_POPPED    = 2'd1;
  localparam status_t ST_OVERFLOW  = 2'd2;
  localparam status_t ST_UNDERFLOW = 2'd3;

  // Configuration register indexes
  localparam cfg_idx_t CFG_RECORD_ENABLE = 3'd0;
  localparam cfg_idx_t CFG_TIMING_THREAD = 3'd1;
  localparam cfg_idx_t CFG_TRACE_ALL     = 3'd2;
  localparam cfg_idx_t CFG_COST_THRESH   = 3'd3;
  localparam cfg_idx_t CFG_MAX_DEPTH     = 3'd4;

  // Configuration reset values
  localparam logic [COST_W-1:0] COST_THRESH_RST = COST_W'(15 * 1000);
  localparam logic [MAXD_W-1:0] MAX_DEPTH_RST   = MAXD_W'(5);

  // One stack entry apart from its timestamp
  typedef struct packed {
    logic [WORD_W-1:0] class_ref;
    logic [WORD_W-1:0] selector_ref;
    logic [WORD_W-1:0] link_addr;
  } entry_t;

endpackage

### hw/rtl/timed_call_stack_filter.sv
// Timed shadow call stack with trace record filter.
// Push and dropped items: result strobe in the cycle after accept, busy stays low,
// so these items may be issued every cycle.
// Pop: busy is high while the top entry is read from stack memory into a register,
// then the result is registered; no new item is accepted while busy. The receiver cannot stall.
// Reset clears the entry count, timestamp valid bits and configuration, not the memories.
module timed_call_stack_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  // item input
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_mode,
  input  logic [tcsf_pkg::WORD_W-1:0]         in_class_ref,
  input  logic [tcsf_pkg::WORD_W-1:0]         in_selector_ref,
  input  logic [tcsf_pkg::WORD_W-1:0]         in_link_addr,
  input  logic [tcsf_pkg::WORD_W-1:0]         in_now_us,
  // result output
  output logic                                out_valid,
  output tcsf_pkg::status_t                   out_status,
  output logic [tcsf_pkg::WORD_W-1:0]         out_return_addr,
  output logic                                out_record_valid,
  output logic [tcsf_pkg::WORD_W-1:0]         out_record_class,
  output logic [tcsf_pkg::WORD_W-1:0]         out_record_selector,
  output logic [tcsf_pkg::REC_DEPTH_W-1:0]    out_record_depth,
  output logic [tcsf_pkg::COST_W-1:0]         out_record_cost_us,
  output logic [tcsf_pkg::WORD_W-1:0]         out_record_start_us,
  // configuration write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  tcsf_pkg::cfg_idx_t                  cfg_index,
  input  logic [tcsf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tcsf_pkg::*;

  localparam int CMP_W = ((CNT_W > MAXD_W) ? CNT_W : MAXD_W) + 1;

  // Configuration registers
  logic              record_enable_r;
  logic              timing_thread_r;
  logic              trace_all_r;
  logic [COST_W-1:0] cost_thresh_r;
  logic [MAXD_W-1:0] max_depth_r;

  // Control state
  logic [CNT_W-1:0]       top_r, top_nxt;
  logic                   busy_r, busy_nxt;
  logic [STACK_DEPTH-1:0] time_vld_r;
  logic                   tvld_rd_r;
  logic [WORD_W-1:0]      now_r;

  // Entry memories
  entry_t            stk_mem  [STACK_DEPTH];
  logic [WORD_W-1:0] time_mem [STACK_DEPTH];
  entry_t            stk_rd_r;
  logic [WORD_W-1:0] time_rd_r;

  // Result registers
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic [WORD_W-1:0] ret_addr_r, ret_addr_nxt;
  logic              rec_vld_r, rec_vld_nxt;
  logic [WORD_W-1:0] rec_class_r, rec_class_nxt;
  logic [WORD_W-1:0] rec_sel_r, rec_sel_nxt;
  logic [REC_DEPTH_W-1:0] rec_depth_r, rec_depth_nxt;
  logic [COST_W-1:0] rec_cost_r, rec_cost_nxt;
  logic [WORD_W-1:0] rec_start_r, rec_start_nxt;

  // Accept decode
  logic             acc, full, empty, push_ok, pop_ok, timing;
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [WORD_W-1:0] t_start;
  logic [COST_W-1:0] cost;
  logic              deep_ok, rec_hit;

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  assign acc     = start && !busy_r;
  assign full    = (top_r == CNT_W'(STACK_DEPTH));
  assign empty   = (top_r == '0);
  assign push_ok = acc && !in_mode && !full;
  assign pop_ok  = acc && in_mode && !empty;
  assign timing  = record_enable_r && timing_thread_r;
  assign wr_ptr  = top_r[PTR_W-1:0];
  assign rd_ptr  = PTR_W'(top_r - CNT_W'(1));

  // Pop evaluation: top_r already holds the popped position here
  assign t_start = tvld_rd_r ? time_rd_r : '0;
  assign cost    = COST_W'(now_r - t_start);
  assign deep_ok = (CMP_W'(top_r) <= CMP_W'(max_depth_r));
  assign rec_hit = timing && (trace_all_r || ((cost > cost_thresh_r) && deep_ok));

  // Next state and result
  always_comb begin
    top_nxt       = top_r;
    busy_nxt      = pop_ok;
    out_valid_nxt = (acc && !pop_ok) || busy_r;
    status_nxt    = ST_PUSHED;
    ret_addr_nxt  = '0;
    rec_vld_nxt   = 1'b0;
    rec_class_nxt = '0;
    rec_sel_nxt   = '0;
    rec_depth_nxt = '0;
    rec_cost_nxt  = '0;
    rec_start_nxt = '0;
    if (busy_r) begin
      status_nxt   = ST_POPPED;
      ret_addr_nxt = stk_rd_r.link_addr;
      if (rec_hit) begin
        rec_vld_nxt   = 1'b1;
        rec_class_nxt = stk_rd_r.class_ref;
        rec_sel_nxt   = stk_rd_r.selector_ref;
        rec_depth_nxt = REC_DEPTH_W'(top_r);
        rec_cost_nxt  = cost;
        rec_start_nxt = t_start;
      end
    end else if (acc) begin
      if (!in_mode) begin
        status_nxt = full ? ST_OVERFLOW : ST_PUSHED;
        if (!full) top_nxt = top_r + CNT_W'(1);
      end else if (empty) begin
        status_nxt = ST_UNDERFLOW;
      end else begin
        top_nxt = top_r - CNT_W'(1);
      end
    end
  end

  // Stack memories: write on push (timestamps only while timing), read top every cycle
  always_ff @(posedge clk) begin
    if (push_ok) begin
      stk_mem[wr_ptr] <= '{class_ref: in_class_ref, selector_ref: in_selector_ref,
                           link_addr: in_link_addr};
    end
    if (push_ok && timing) begin
      time_mem[wr_ptr] <= in_now_us;
    end
    stk_rd_r  <= stk_mem[rd_ptr];
    time_rd_r <= time_mem[rd_ptr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      time_vld_r  <= '0;
      tvld_rd_r   <= 1'b0;
    end else begin
      top_r       <= top_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      tvld_rd_r   <= time_vld_r[rd_ptr];
      if (push_ok && timing) time_vld_r[wr_ptr] <= 1'b1;
    end
  end

  // Hold pop timestamp and result payload
  always_ff @(posedge clk) begin
    if (acc) now_r <= in_now_us;
    status_r    <= status_nxt;
    ret_addr_r  <= ret_addr_nxt;
    rec_vld_r   <= rec_vld_nxt;
    rec_class_r <= rec_class_nxt;
    rec_sel_r   <= rec_sel_nxt;
    rec_depth_r <= rec_depth_nxt;
    rec_cost_r  <= rec_cost_nxt;
    rec_start_r <= rec_start_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_enable_r <= 1'b0;
      timing_thread_r <= 1'b1;
      trace_all_r     <= 1'b0;
      cost_thresh_r   <= COST_THRESH_RST;
      max_depth_r     <= MAX_DEPTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RECORD_ENABLE: record_enable_r <= cfg_data[0];
        CFG_TIMING_THREAD: timing_thread_r <= cfg_data[0];
        CFG_TRACE_ALL:     trace_all_r     <= cfg_data[0];
        CFG_COST_THRESH:   cost_thresh_r   <= cfg_data[COST_W-1:0];
        CFG_MAX_DEPTH:     max_depth_r     <= cfg_data[MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_return_addr     = ret_addr_r;
  assign out_record_valid    = rec_vld_r;
  assign out_record_class    = rec_class_r;
  assign out_record_selector = rec_sel_r;
  assign out_record_depth    = rec_depth_r;
  assign out_record_cost_us  = rec_cost_r;
  assign out_record_start_us = rec_start_r;

`ifndef SYNTHESIS
  // A pop holds the input side for exactly one extra cycle
  a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> !busy_r) else $error("busy held beyond one cycle");

  // Entry count never passes the stack depth
  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= CNT_W'(STACK_DEPTH)) else $error("stack count out of range");

  // A popped result always follows the memory read cycle
  a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_POPPED) |-> $past(busy_r))
    else $error("popped result without memory read");

  // A record only comes with a popped result
  a_rec_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rec_vld_r) |-> (status_r == ST_POPPED))
    else $error("record on a non-pop result");
`endif

endmodule
